// File: design/tld_pkg.sv
// tld_pkg: shared types, constants and codes of the tty line discipline
// no dependencies; imported by every module of the block but tld_ram
`timescale 1ns / 1ps
package tld_pkg;

    localparam int unsigned C_LINE_DEPTH = 32;
    localparam int unsigned C_READ_DEPTH = 64;

    localparam logic [7:0] C_DEL        = 8'd127;
    localparam logic [7:0] C_CTL_OFFSET = 8'h40;
    localparam logic [7:0] C_CTL_LIMIT  = 8'd32;
    localparam logic [7:0] C_NL         = 8'd10;
    localparam logic [7:0] C_CR         = 8'd13;
    localparam logic [7:0] C_TAB        = 8'd9;
    localparam logic [5:0] C_MAX_READ   = 6'd32;

    // item kinds
    localparam logic [1:0] K_PUT   = 2'd0;
    localparam logic [1:0] K_READ  = 2'd1;
    localparam logic [1:0] K_FLUSH = 2'd2;

    // result kinds
    localparam logic [1:0] OK_ECHO   = 2'd0;
    localparam logic [1:0] OK_DATA   = 2'd1;
    localparam logic [1:0] OK_STATUS = 2'd2;

    // signal events
    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_INTR = 2'd1;
    localparam logic [1:0] SIG_SUSP = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_ERASE = 3'd1;
    localparam logic [2:0] CFG_KILL  = 3'd2;
    localparam logic [2:0] CFG_EOF   = 3'd3;
    localparam logic [2:0] CFG_EOL   = 3'd4;
    localparam logic [2:0] CFG_INTR  = 3'd5;
    localparam logic [2:0] CFG_SUSP  = 3'd6;
    localparam logic [2:0] CFG_MIN   = 3'd7;

    // mode flag bit positions
    localparam int unsigned FB_ICANON  = 0;
    localparam int unsigned FB_ECHO    = 1;
    localparam int unsigned FB_ECHOE   = 2;
    localparam int unsigned FB_ECHOK   = 3;
    localparam int unsigned FB_ECHONL  = 4;
    localparam int unsigned FB_ISIG    = 5;
    localparam int unsigned FB_NOFLSH  = 6;
    localparam int unsigned FB_ECHOCTL = 7;
    localparam int unsigned FB_ICRNL   = 8;
    localparam int unsigned FB_IGNCR   = 9;
    localparam int unsigned FB_INLCR   = 10;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_req;
        logic [5:0] read_count;
    } t_in_item;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [1:0] signal_event;
        logic       line_ready;
        logic       dropped;
        logic [5:0] delivered;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [10:0] mode_flags;
        logic [7:0]  erase_char;
        logic [7:0]  kill_char;
        logic [7:0]  eof_char;
        logic [7:0]  eol_char;
        logic [7:0]  intr_char;
        logic [7:0]  susp_char;
        logic [7:0]  min_count;
    } t_cfg;

    localparam t_cfg C_CFG_RESET = '{
        mode_flags: 11'd175, erase_char: 8'd127, kill_char: 8'd21, eof_char: 8'd4,
        eol_char: 8'd255, intr_char: 8'd3, susp_char: 8'd26, min_count: 8'd1
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ECHO,
        ST_EOL,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_STATUS
    } t_state;

endpackage

// File: design/tld_ram.sv
// tld_ram: simple dual port byte store, one write and one registered read
// depends on nothing
`timescale 1ns / 1ps
module tld_ram #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/tld_cfg.sv
// tld_cfg: configuration register file written over its own valid/ready channel
// depends on tld_pkg
`timescale 1ns / 1ps
module tld_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [2:0]    i_cfg_index,
    input  logic [10:0]   i_cfg_data,
    output logic          o_cfg_ready,
    output tld_pkg::t_cfg o_cfg
);
    import tld_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:  n_cfg.mode_flags = i_cfg_data;
                CFG_ERASE: n_cfg.erase_char = i_cfg_data[7:0];
                CFG_KILL:  n_cfg.kill_char  = i_cfg_data[7:0];
                CFG_EOF:   n_cfg.eof_char   = i_cfg_data[7:0];
                CFG_EOL:   n_cfg.eol_char   = i_cfg_data[7:0];
                CFG_INTR:  n_cfg.intr_char  = i_cfg_data[7:0];
                CFG_SUSP:  n_cfg.susp_char  = i_cfg_data[7:0];
                CFG_MIN:   n_cfg.min_count  = i_cfg_data[7:0];
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= C_CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
endmodule

// File: design/tld_core.sv
// tld_core: sequencer walking the line and read stores one byte a step
// depends on tld_pkg and tld_ram
`timescale 1ns / 1ps
module tld_core #(
    parameter int unsigned LINE_DEPTH = 32,
    parameter int unsigned READ_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tld_pkg::t_cfg      i_cfg,
    input  logic               start,
    input  tld_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_strobe,
    output tld_pkg::t_out_item o_result
);
    import tld_pkg::*;

    localparam int unsigned LW = $clog2(LINE_DEPTH + 1);
    localparam int unsigned LA = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int unsigned RW = $clog2(READ_DEPTH + 1);
    localparam int unsigned RA = (READ_DEPTH > 1) ? $clog2(READ_DEPTH) : 1;
    localparam int unsigned SW = ((LW > RW) ? LW : RW) + 1;

    function automatic logic [RA-1:0] f_inc(input logic [RA-1:0] p);
        logic [RA:0] s;
        s = {1'b0, p} + 1'b1;
        if (s == (RA+1)'(READ_DEPTH)) begin
            s = '0;
        end
        return s[RA-1:0];
    endfunction

    function automatic logic [5:0] f_sat32(input logic [8:0] v);
        return (v > 9'd32) ? 6'd32 : v[5:0];
    endfunction

    t_state          r_state, n_state;
    logic [1:0]      r_kind, n_kind;
    logic [7:0]      r_byte, n_byte;
    logic [LW-1:0]   r_line_len, n_line_len;
    logic [LW-1:0]   r_old_len, n_old_len;
    logic [LW-1:0]   r_idx, n_idx;
    logic [RW-1:0]   r_read_len, n_read_len;
    logic [RA-1:0]   r_head, n_head;
    logic [RA-1:0]   r_wp, n_wp;
    logic [5:0]      r_cnt, n_cnt;
    logic [7:0]      r_run_byte, n_run_byte;
    logic            r_eol, n_eol;
    logic [1:0]      r_sig, n_sig;
    logic            r_ready, n_ready;
    logic            r_drop, n_drop;
    logic [5:0]      r_deliv, n_deliv;
    t_out_item       r_out, n_out;
    logic            r_out_v, n_out_v;

    logic            line_we;
    logic [LA-1:0]   line_waddr;
    logic [7:0]      line_rdata;
    logic            read_we;
    logic [7:0]      read_rdata;

    // put decode
    logic            canon;
    logic [7:0]      c;
    logic            discard, eol, echo, kill, del, flush, ctl;
    logic [LW-1:0]   len, len_after;
    logic [7:0]      x;
    logic [1:0]      sig;
    logic [5:0]      p_cnt;
    logic [7:0]      p_byte;
    logic [SW-1:0]   fit_sum, wp_sum;

    assign canon = i_cfg.mode_flags[FB_ICANON];

    always_comb begin
        c       = r_byte;
        discard = 1'b0;
        if (r_byte == C_CR) begin
            if (i_cfg.mode_flags[FB_IGNCR]) begin
                discard = 1'b1;
            end else if (i_cfg.mode_flags[FB_ICRNL]) begin
                c = C_NL;
            end
        end else if (r_byte == C_NL && i_cfg.mode_flags[FB_INLCR]) begin
            c = C_CR;
        end
        if (canon) begin
            eol = (c == C_NL) || (c == i_cfg.eol_char) || (c == i_cfg.eof_char);
        end else begin
            eol = (9'(r_line_len) + 9'd1) >= {1'b0, i_cfg.min_count};
        end
        len   = r_line_len;
        echo  = i_cfg.mode_flags[FB_ECHO];
        kill  = 1'b0;
        del   = 1'b0;
        flush = 1'b0;
        sig   = SIG_NONE;
        if (canon && c == i_cfg.erase_char) begin
            discard = 1'b1;
            del     = 1'b1;
            if (len != '0) begin
                len = len - 1'b1;
            end else begin
                echo = 1'b0;
            end
            if (!i_cfg.mode_flags[FB_ECHOE]) begin
                echo = 1'b0;
            end
        end
        if (canon && c == i_cfg.kill_char) begin
            discard = 1'b1;
            kill    = 1'b1;
            echo    = i_cfg.mode_flags[FB_ECHOK];
        end
        if (i_cfg.mode_flags[FB_ISIG] && c == i_cfg.intr_char) begin
            sig     = SIG_INTR;
            flush   = flush | !i_cfg.mode_flags[FB_NOFLSH];
            discard = 1'b1;
            eol     = 1'b0;
        end
        if (i_cfg.mode_flags[FB_ISIG] && c == i_cfg.susp_char) begin
            if (sig == SIG_NONE) begin
                sig = SIG_SUSP;
            end
            flush   = flush | !i_cfg.mode_flags[FB_NOFLSH];
            discard = 1'b1;
            eol     = 1'b0;
        end
        if (flush) begin
            len = '0;
        end
        if (c == C_NL && canon && i_cfg.mode_flags[FB_ECHONL]) begin
            echo = 1'b1;
        end
        line_waddr = len[LA-1:0];
        len_after  = discard ? len : len + 1'b1;
        ctl = (c < C_CTL_LIMIT) && i_cfg.mode_flags[FB_ECHOCTL] && (c != C_NL) && (c != C_TAB);
        x   = ctl ? c + C_CTL_OFFSET : c;
        // kill and erase both discard; a kill that is also the erase char adds one DEL
        p_cnt  = '0;
        p_byte = C_DEL;
        if (echo && !discard) begin
            if (x == i_cfg.kill_char) begin
                p_cnt = f_sat32(9'(len_after));
            end else if (x == i_cfg.erase_char) begin
                p_cnt = 6'd1;
            end else begin
                p_byte = x;
                p_cnt  = 6'd1;
            end
        end else if (kill && echo) begin
            p_cnt = f_sat32(9'(len) + {8'b0, del});
        end else if (del && echo) begin
            p_cnt = 6'd1;
        end
        fit_sum = SW'(r_read_len) + SW'(r_line_len);
        wp_sum  = SW'(r_head) + SW'(r_read_len);
        if (wp_sum >= SW'(READ_DEPTH)) begin
            wp_sum = wp_sum - SW'(READ_DEPTH);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_byte     = r_byte;
        n_line_len = r_line_len;
        n_old_len  = r_old_len;
        n_idx      = r_idx;
        n_read_len = r_read_len;
        n_head     = r_head;
        n_wp       = r_wp;
        n_cnt      = r_cnt;
        n_run_byte = r_run_byte;
        n_eol      = r_eol;
        n_sig      = r_sig;
        n_ready    = r_ready;
        n_drop     = r_drop;
        n_deliv    = r_deliv;
        n_out      = '0;
        n_out_v    = 1'b0;
        line_we    = 1'b0;
        read_we    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_kind  = i_item.kind;
                    n_byte  = i_item.byte_req;
                    n_cnt   = (i_item.read_count > C_MAX_READ) ? C_MAX_READ
                                                               : i_item.read_count;
                    n_sig   = SIG_NONE;
                    n_ready = 1'b0;
                    n_drop  = 1'b0;
                    n_deliv = '0;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (r_kind)
                    K_PUT: begin
                        if (r_line_len >= LW'(LINE_DEPTH)) begin
                            n_drop  = 1'b1;
                            n_state = ST_STATUS;
                        end else begin
                            line_we    = !discard;
                            n_old_len  = r_line_len;
                            n_line_len = kill ? '0 : len_after;
                            if (flush) begin
                                n_read_len = '0;
                            end
                            n_sig      = sig;
                            n_cnt      = p_cnt;
                            n_run_byte = p_byte;
                            n_eol      = eol;
                            n_state    = ST_ECHO;
                        end
                    end
                    K_READ: begin
                        n_state = ST_RD_ADDR;
                    end
                    K_FLUSH: begin
                        n_line_len = '0;
                        n_read_len = '0;
                        n_state    = ST_STATUS;
                    end
                    default: begin
                        n_state = ST_STATUS;
                    end
                endcase
            end
            ST_ECHO: begin
                if (r_cnt != '0) begin
                    n_out.out_kind = OK_ECHO;
                    n_out.out_byte = r_run_byte;
                    n_out_v        = 1'b1;
                    n_cnt          = r_cnt - 1'b1;
                end else begin
                    n_state = ST_EOL;
                end
            end
            ST_EOL: begin
                if (!r_eol) begin
                    n_state = ST_STATUS;
                end else if (fit_sum > SW'(READ_DEPTH)) begin
                    n_line_len = r_old_len;
                    n_drop     = 1'b1;
                    n_state    = ST_STATUS;
                end else begin
                    n_wp    = wp_sum[RA-1:0];
                    n_idx   = '0;
                    n_state = ST_COPY_RD;
                end
            end
            ST_COPY_RD: begin
                if (r_idx == r_line_len) begin
                    n_read_len = RW'(fit_sum);
                    n_line_len = '0;
                    n_ready    = 1'b1;
                    n_state    = ST_STATUS;
                end else begin
                    n_state = ST_COPY_WR;
                end
            end
            ST_COPY_WR: begin
                read_we = 1'b1;
                n_wp    = f_inc(r_wp);
                n_idx   = r_idx + 1'b1;
                n_state = ST_COPY_RD;
            end
            ST_RD_ADDR: begin
                if (r_read_len != '0 && r_cnt != '0) begin
                    n_state = ST_RD_DATA;
                end else begin
                    n_state = ST_STATUS;
                end
            end
            ST_RD_DATA: begin
                if (!canon || read_rdata != i_cfg.eof_char) begin
                    n_out.out_kind = OK_DATA;
                    n_out.out_byte = read_rdata;
                    n_out_v        = 1'b1;
                    n_deliv        = r_deliv + 1'b1;
                end
                n_head     = f_inc(r_head);
                n_read_len = r_read_len - 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (canon && (read_rdata == C_NL || read_rdata == i_cfg.eol_char
                              || read_rdata == i_cfg.eof_char)) begin
                    n_state = ST_STATUS;
                end else begin
                    n_state = ST_RD_ADDR;
                end
            end
            ST_STATUS: begin
                n_out.out_kind     = OK_STATUS;
                n_out.signal_event = r_sig;
                n_out.line_ready   = r_ready;
                n_out.dropped      = r_drop;
                n_out.delivered    = r_deliv;
                n_out.last         = 1'b1;
                n_out_v            = 1'b1;
                n_state            = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_line_len <= '0;
            r_read_len <= '0;
            r_head     <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_line_len <= n_line_len;
            r_read_len <= n_read_len;
            r_head     <= n_head;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_byte     <= n_byte;
        r_old_len  <= n_old_len;
        r_idx      <= n_idx;
        r_wp       <= n_wp;
        r_cnt      <= n_cnt;
        r_run_byte <= n_run_byte;
        r_eol      <= n_eol;
        r_sig      <= n_sig;
        r_ready    <= n_ready;
        r_drop     <= n_drop;
        r_deliv    <= n_deliv;
        r_out      <= n_out;
    end

    tld_ram #(.DEPTH(LINE_DEPTH), .AW(LA)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (line_waddr),
        .i_wdata (c),
        .i_raddr (r_idx[LA-1:0]),
        .o_rdata (line_rdata)
    );

    // read store is a ring: r_head is the oldest byte
    tld_ram #(.DEPTH(READ_DEPTH), .AW(RA)) u_read_ram (
        .i_clk   (i_clk),
        .i_we    (read_we),
        .i_waddr (r_wp),
        .i_wdata (line_rdata),
        .i_raddr (r_head),
        .o_rdata (read_rdata)
    );

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_out_v;
    assign o_result = r_out;

`ifndef SYNTH
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.last |-> r_state == ST_IDLE)
        else $error("status beat while item still running");
    a_no_beat_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && r_state == ST_IDLE |=> !r_out_v)
        else $error("beat right after accept");
    a_read_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read_len <= RW'(READ_DEPTH) && r_line_len <= LW'(LINE_DEPTH))
        else $error("store length beyond depth");
    a_copy_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_COPY_WR |-> fit_sum <= SW'(READ_DEPTH))
        else $error("line copy overruns read store");
`endif
endmodule

// File: design/tty_line_discipline.sv
// tty_line_discipline: top level, config registers plus byte sequencer
// depends on tld_pkg, tld_cfg, tld_core (and tld_ram below it)
// busy spans decode, echo beats and, when a line moves, a read and a write state per byte;
// a read has an address and a data state per byte, stopping at a line end; flush, unknown
// kind or full line store go to status; status beat follows with busy low; receiver cannot stall
// synchronous active-low reset empties both stores; no clearing pass is needed
`timescale 1ns / 1ps
module tty_line_discipline #(
    parameter int unsigned LINE_DEPTH = tld_pkg::C_LINE_DEPTH,
    parameter int unsigned READ_DEPTH = tld_pkg::C_READ_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  tld_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_strobe,
    output tld_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [10:0]        i_cfg_data,
    output logic               o_cfg_ready
);
    import tld_pkg::*;

    t_cfg cfg;

    tld_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    tld_core #(.LINE_DEPTH(LINE_DEPTH), .READ_DEPTH(READ_DEPTH)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );
endmodule

// File: sim/tty_line_discipline_tb.sv
// tty_line_discipline_tb: self-checking bench for the terminal line discipline
// depends on tld_pkg and tty_line_discipline; a local model predicts every result beat
`timescale 1ns / 1ps
module tty_line_discipline_tb;
    import tld_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    // kind code with no operation behind it
    localparam logic [1:0] K_RESERVED = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    t_in_item   i_item = '0;
    logic       busy;
    logic       o_strobe;
    t_out_item  o_result;
    logic       i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;
    logic       o_cfg_ready;

    tty_line_discipline uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item), .busy(busy),
        .o_strobe(o_strobe), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .o_cfg_ready(o_cfg_ready)
    );

    always #5 i_clk = ~i_clk;

    // model state
    t_cfg       ldisc_cfg;
    logic [7:0] line_buf [C_LINE_DEPTH];
    int         line_len;
    logic [7:0] read_buf [C_READ_DEPTH];
    int         read_len;
    int         beat_count;
    t_out_item  expected_beats [$];

    int errors = 0;
    int items_sent = 0;
    int beats_checked = 0;
    int idle_cycles = 0;

    // ---------------- model ----------------
    task automatic push_beat(logic [1:0] k, logic [7:0] b);
        t_out_item r;
        if (beat_count < 32) begin
            r = '0;
            r.out_kind = k;
            r.out_byte = b;
            expected_beats.push_back(r);
            beat_count++;
        end
    endtask

    task automatic echo_byte(logic [7:0] b);
        if (b == ldisc_cfg.kill_char) begin
            for (int k = 0; k < line_len; k++) push_beat(OK_ECHO, C_DEL);
        end else if (b == ldisc_cfg.erase_char) begin
            push_beat(OK_ECHO, C_DEL);
        end else begin
            push_beat(OK_ECHO, b);
        end
    endtask

    function automatic bit is_line_end(logic [7:0] c);
        return c == C_NL || c == ldisc_cfg.eol_char || c == ldisc_cfg.eof_char;
    endfunction

    task automatic predict_item(t_in_item it);
        logic [10:0] m;
        logic [1:0]  sig;
        logic        ready, drop;
        int          deliv, old, rc, done;
        logic [7:0]  c, v;
        bit          canon, discard, eol, echo, kill, del;
        t_out_item   st;
        m = ldisc_cfg.mode_flags;
        sig = SIG_NONE; ready = 0; drop = 0; deliv = 0;
        canon = m[FB_ICANON];
        beat_count = 0;
        if (it.kind == K_PUT) begin
            if (line_len >= C_LINE_DEPTH) begin
                drop = 1;
            end else begin
                old = line_len; c = it.byte_req;
                discard = 0; kill = 0; del = 0;
                if (c == C_CR) begin
                    if (m[FB_IGNCR]) discard = 1;
                    else if (m[FB_ICRNL]) c = C_NL;
                end else if (c == C_NL && m[FB_INLCR]) begin
                    c = C_CR;
                end
                if (canon) eol = is_line_end(c);
                else eol = (line_len + 1) >= int'(ldisc_cfg.min_count);
                echo = m[FB_ECHO];
                if (canon && c == ldisc_cfg.erase_char) begin
                    discard = 1; del = 1;
                    if (line_len > 0) line_len--;
                    else echo = 0;
                    if (!m[FB_ECHOE]) echo = 0;
                end
                if (canon && c == ldisc_cfg.kill_char) begin
                    discard = 1; kill = 1;
                    echo = m[FB_ECHOK];
                end
                if (m[FB_ISIG] && c == ldisc_cfg.intr_char) begin
                    sig = SIG_INTR;
                    if (!m[FB_NOFLSH]) begin
                        line_len = 0; read_len = 0;
                    end
                    discard = 1; eol = 0;
                end
                if (m[FB_ISIG] && c == ldisc_cfg.susp_char) begin
                    if (sig == SIG_NONE) sig = SIG_SUSP;
                    if (!m[FB_NOFLSH]) begin
                        line_len = 0; read_len = 0;
                    end
                    discard = 1; eol = 0;
                end
                if (c == C_NL && canon && m[FB_ECHONL]) echo = 1;
                if (!discard && line_len < C_LINE_DEPTH) begin
                    line_buf[line_len] = c;
                    line_len++;
                end
                if (echo && !discard) begin
                    if (c < C_CTL_LIMIT && m[FB_ECHOCTL] && c != C_NL && c != C_TAB)
                        echo_byte(C_CTL_OFFSET + c);
                    else
                        echo_byte(c);
                end
                if (kill && echo)
                    for (int k = 0; k < line_len; k++) push_beat(OK_ECHO, C_DEL);
                if (kill) line_len = 0;
                if (del && echo) push_beat(OK_ECHO, C_DEL);
                if (eol) begin
                    if (C_READ_DEPTH - read_len < line_len) begin
                        line_len = old;
                        drop = 1;
                    end else begin
                        for (int k = 0; k < line_len; k++) read_buf[read_len + k] = line_buf[k];
                        read_len += line_len;
                        line_len = 0;
                        ready = 1;
                    end
                end
            end
        end else if (it.kind == K_READ) begin
            rc = (it.read_count > 32) ? 32 : int'(it.read_count);
            done = 0;
            while (done < read_len && done < rc) begin
                v = read_buf[done];
                if (!canon || v != ldisc_cfg.eof_char) begin
                    push_beat(OK_DATA, v);
                    deliv++;
                end
                done++;
                if (canon && is_line_end(v)) break;
            end
            if (done > 0) begin
                for (int k = 0; k < read_len - done; k++) read_buf[k] = read_buf[k + done];
                read_len -= done;
            end
        end else if (it.kind == K_FLUSH) begin
            line_len = 0; read_len = 0;
        end
        st = '0;
        st.out_kind = OK_STATUS;
        st.signal_event = sig;
        st.line_ready = ready;
        st.dropped = drop;
        st.delivered = deliv[5:0];
        st.last = 1'b1;
        expected_beats.push_back(st);
    endtask

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat: %h", o_result);
            end else begin
                t_out_item e;
                e = expected_beats.pop_front();
                if (o_result.out_kind !== e.out_kind || o_result.out_byte !== e.out_byte ||
                    o_result.signal_event !== e.signal_event ||
                    o_result.line_ready !== e.line_ready || o_result.dropped !== e.dropped ||
                    o_result.delivered !== e.delivered || o_result.last !== e.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: exp kind=%0d byte=%h sig=%0d rdy=%b drp=%b dlv=%0d last=%b",
                            e.out_kind, e.out_byte, e.signal_event, e.line_ready, e.dropped,
                            e.delivered, e.last);
                        $display("          got kind=%0d byte=%h sig=%0d rdy=%b drp=%b dlv=%0d last=%b",
                            o_result.out_kind, o_result.out_byte, o_result.signal_event,
                            o_result.line_ready, o_result.dropped, o_result.delivered,
                            o_result.last);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat of any kind
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("FAIL tty_line_discipline");
            $finish;
        end
    end

    // ---------------- driver tasks ----------------
    task automatic send_item(logic [1:0] k, logic [7:0] b, logic [5:0] rc, int gap);
        t_in_item it;
        it.kind = k; it.byte_req = b; it.read_count = rc;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predict_item(it);
        items_sent++;
    endtask

    task automatic put(logic [7:0] b);
        send_item(K_PUT, b, 6'($urandom), $urandom_range(0, 11));
    endtask

    task automatic read_req(logic [5:0] rc);
        send_item(K_READ, 8'($urandom), rc, $urandom_range(0, 11));
    endtask

    // hold off until every expected beat is in and the block is quiet
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [10:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODE:  ldisc_cfg.mode_flags = data;
            CFG_ERASE: ldisc_cfg.erase_char = data[7:0];
            CFG_KILL:  ldisc_cfg.kill_char = data[7:0];
            CFG_EOF:   ldisc_cfg.eof_char = data[7:0];
            CFG_EOL:   ldisc_cfg.eol_char = data[7:0];
            CFG_INTR:  ldisc_cfg.intr_char = data[7:0];
            CFG_SUSP:  ldisc_cfg.susp_char = data[7:0];
            default:   ldisc_cfg.min_count = data[7:0];
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_all(logic [10:0] m, logic [7:0] er, logic [7:0] kl, logic [7:0] ef,
                           logic [7:0] el, logic [7:0] it, logic [7:0] sp, logic [7:0] mn);
        drain();
        cfg_write(CFG_MODE, m);
        cfg_write(CFG_ERASE, {3'b0, er});
        cfg_write(CFG_KILL, {3'b0, kl});
        cfg_write(CFG_EOF, {3'b0, ef});
        cfg_write(CFG_EOL, {3'b0, el});
        cfg_write(CFG_INTR, {3'b0, it});
        cfg_write(CFG_SUSP, {3'b0, sp});
        cfg_write(CFG_MIN, {3'b0, mn});
    endtask

    // ---------------- tests ----------------
    task automatic test_canonical_edit();
        put("a"); put(8'h01); put(C_CR); read_req(6'd63);
        put("x"); put("y"); put(8'd127); put(8'd21); put(8'd127);
        put("z"); put(8'd4); read_req(6'd0); read_req(6'd5);
        send_item(K_RESERVED, 8'hFF, 6'h3F, 0);
    endtask

    task automatic test_signals_and_flush();
        put("q"); put(8'd3); put("r"); put(C_NL); put(8'd26);
        send_item(K_FLUSH, 8'd0, 6'd0, 3); read_req(6'd32);
        drain();
    endtask

    task automatic test_mapping_and_ctl();
        // igncr, inlcr, echonl and shared intr/susp
        cfg_all(11'h7BF, 8'd8, 8'd24, 8'd0, 8'd13, 8'd28, 8'd28, 8'd1);
        put(C_CR); put(8'h09); put(8'h1F); put(C_NL); put(8'd28); put(8'd8);
        read_req(6'd40);
        // icrnl without igncr
        cfg_all(11'h1BF, 8'd127, 8'd21, 8'd4, 8'd255, 8'd3, 8'd26, 8'd1);
        put(C_CR); read_req(6'd1);
    endtask

    task automatic test_store_overflow();
        // fill the line store, then one more byte is dropped
        for (int i = 0; i < 33; i++) send_item(K_PUT, 8'h61 + i[4:0] % 20, 6'd0, 0);
        put(C_NL);
        put(C_NL); put(C_NL);
        // more puts while the line store is still full; each of them is dropped
        for (int i = 0; i < 30; i++) send_item(K_PUT, "k", 6'd0, 0);
        put(C_NL);
        send_item(K_FLUSH, 8'd0, 6'd0, 0);
        drain();
    endtask

    task automatic test_raw_mode();
        cfg_all(11'h000, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        put(8'd0); put(8'hFF); read_req(6'd2);
        cfg_all(11'h7FE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        put(8'd13); put(8'd10); put(8'h41); read_req(6'd63);
        send_item(K_FLUSH, 8'd0, 6'd0, 0);
    endtask

    task automatic random_phase(int n, logic [10:0] m);
        int   r;
        logic [7:0] ch;
        cfg_all(m, 8'($urandom_range(0, 127)), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom),
                m[FB_ICANON] ? 8'($urandom) : 8'($urandom_range(0, 6)));
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                case ($urandom_range(0, 9))
                    0: ch = ldisc_cfg.erase_char;
                    1: ch = ldisc_cfg.kill_char;
                    2: ch = ldisc_cfg.eof_char;
                    3: ch = C_NL;
                    4: ch = C_CR;
                    5: ch = ($urandom_range(0, 3) == 0) ? ldisc_cfg.intr_char
                                                        : ldisc_cfg.susp_char;
                    6: ch = 8'($urandom_range(0, 31));
                    default: ch = 8'($urandom);
                endcase
                put(ch);
            end else if (r < 90) begin
                read_req(6'($urandom));
            end else if (r < 95) begin
                send_item(K_FLUSH, 8'($urandom), 6'($urandom), $urandom_range(0, 11));
            end else begin
                send_item(K_RESERVED, 8'($urandom), 6'($urandom), $urandom_range(0, 11));
            end
            // a run of back-to-back puts now and then
            if (i % 8 == 6) for (int j = 0; j < 6; j++) send_item(K_PUT, "s", 6'd1, 0);
        end
    endtask

    initial begin
        ldisc_cfg = C_CFG_RESET;
        line_len = 0; read_len = 0;
        for (int k = 0; k < C_LINE_DEPTH; k++) line_buf[k] = '0;
        for (int k = 0; k < C_READ_DEPTH; k++) read_buf[k] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_canonical_edit();
        test_signals_and_flush();
        test_mapping_and_ctl();
        test_store_overflow();
        test_raw_mode();
        random_phase(8, 11'd175);
        random_phase(8, 11'($urandom) | 11'h001);
        random_phase(8, 11'($urandom) & 11'h7FE);
        random_phase(8, 11'h7FF);
        random_phase(8, 11'($urandom));

        drain();
        repeat (20) @(posedge i_clk);
        if (expected_beats.size() != 0) errors++;
        $display("ran %0d items in canonical and raw settings, %0d result beats checked",
                 items_sent, beats_checked);
        if (errors == 0) begin
            $display("PASS tty_line_discipline");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL tty_line_discipline");
        end
        $finish;
    end
endmodule
